/* sv/idsc_pkg.sv */
// ----------------------------------------------------------------------------
// idsc_pkg
// Shared types and constants of the idle dim/sleep display power controller.
// ----------------------------------------------------------------------------
package idsc_pkg;

   localparam int TIME_W    = 32;
   localparam int LEVEL_W   = 7;
   localparam int TIMEOUT_W = 16;
   localparam int THRESH_W  = 26;   // TIMEOUT_W seconds scaled to milliseconds
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [THRESH_W-1:0] MS_PER_S     = THRESH_W'(1000);
   localparam logic [LEVEL_W-1:0]  MAX_PERCENT  = LEVEL_W'(100);
   localparam logic [LEVEL_W-1:0]  DIM_FLOOR    = LEVEL_W'(5);
   localparam int                  DIM_SHIFT    = 2;   // dimmed level is a quarter
   localparam logic [LEVEL_W-1:0]  LEVEL_OFF    = '0;

   // register index, taken from paddr[2]
   typedef enum logic [0:0] {
      REG_BRIGHTNESS = 1'b0,
      REG_TIMEOUT    = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_AWAKE  = 2'd0,
      MODE_DIMMED = 2'd1,
      MODE_ASLEEP = 2'd2
   } power_mode_type;

   typedef enum logic [0:0] {
      KIND_POLL     = 1'b0,
      KIND_ACTIVITY = 1'b1
   } item_kind_type;

   function automatic logic [LEVEL_W-1:0] clamp_percent(input logic [LEVEL_W-1:0] v);
      return (v > MAX_PERCENT) ? MAX_PERCENT : v;
   endfunction

   function automatic logic [LEVEL_W-1:0] dim_level(input logic [LEVEL_W-1:0] b);
      logic [LEVEL_W-1:0] q;
      q = b >> DIM_SHIFT;
      return (q < DIM_FLOOR) ? DIM_FLOOR : q;
   endfunction

endpackage

/* sv/idsc_req_if.sv */
// ----------------------------------------------------------------------------
// idsc_req_if
// Input channel: activity events and polls with a millisecond timestamp.
// ----------------------------------------------------------------------------
interface idsc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [idsc_pkg::TIME_W-1:0]     now_ms;

   modport source (output valid, output kind, output now_ms, input ready);
   modport sink   (input valid, input kind, input now_ms, output ready);
endinterface

/* sv/idsc_rsp_if.sv */
// ----------------------------------------------------------------------------
// idsc_rsp_if
// Result channel: power mode, applied brightness and the applied flag.
// ----------------------------------------------------------------------------
interface idsc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      power_mode;
   logic [idsc_pkg::LEVEL_W-1:0]    brightness;
   logic                            brightness_applied;

   modport source (output valid, output power_mode, output brightness,
                   output brightness_applied, input ready);
   modport sink   (input valid, input power_mode, input brightness,
                   input brightness_applied, output ready);
endinterface

/* sv/idle_dim_sleep_controller_top.sv */
// ----------------------------------------------------------------------------
// idle_dim_sleep_controller_top
// Display power controller: awake / dimmed / asleep driven by activity
// events and inactivity polls, with an APB-style register port.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-----------------------------------
//   req_ch  | in        | valid / ready    | kind, now_ms
//   rsp_ch  | out       | valid / ready    | power_mode, brightness,
//           |           |                  | brightness_applied
//   APB     | in        | psel/penable     | paddr, pwdata -> prdata
//
// One transfer per cycle in steady state while rsp ready stays high. rsp valid
// rises after the req transfer once the item has passed the input register and
// then the result register.
// The mode / last-activity state is updated at the edge that loads the result
// register, so each item sees the state left by the one before it.
// A stalled rsp holds the result register; the input register still takes one
// more item, after which req ready drops until the result is taken.
// Reset (synchronous) empties both stages and restores register defaults.
//
module idle_dim_sleep_controller_top (
   input  logic                             clock,
   input  logic                             reset,
   idsc_req_if.sink                         req_ch,
   idsc_rsp_if.source                       rsp_ch,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [idsc_pkg::ADDR_W-1:0]      paddr,
   input  logic [idsc_pkg::DATA_W-1:0]      pwdata,
   output logic [idsc_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);
   import idsc_pkg::*;

   // ---------------- configuration registers ----------------
   logic [LEVEL_W-1:0]    bright_ff;     // awake level, already clamped
   logic [LEVEL_W-1:0]    dim_lvl_ff;    // quarter of bright_ff, floor 5
   logic [TIMEOUT_W-1:0]  timeout_ff;
   logic [THRESH_W-1:0]   sleep_ms_ff;   // timeout in ms
   logic [THRESH_W-1:0]   dim_ms_ff;     // half timeout (rounded down) in ms

   logic                  cfg_wr;
   reg_index_type         cfg_idx;
   logic [LEVEL_W-1:0]    wr_bright;
   logic [TIMEOUT_W-1:0]  wr_timeout;

   assign pready     = 1'b1;
   assign cfg_wr     = psel && penable && pwrite;
   assign cfg_idx    = reg_index_type'(paddr[2]);
   assign wr_bright  = clamp_percent(pwdata[LEVEL_W-1:0]);
   assign wr_timeout = pwdata[TIMEOUT_W-1:0];

   // Thresholds are scaled to milliseconds when the register is written, so a
   // poll compares raw elapsed ms and never divides: floor(e/1000) >= T
   // exactly when e >= T*1000.
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff   <= MAX_PERCENT;
         dim_lvl_ff  <= dim_level(MAX_PERCENT);
         timeout_ff  <= '0;
         sleep_ms_ff <= '0;
         dim_ms_ff   <= '0;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_BRIGHTNESS: begin
               bright_ff  <= wr_bright;
               dim_lvl_ff <= dim_level(wr_bright);
            end
            REG_TIMEOUT: begin
               timeout_ff  <= wr_timeout;
               sleep_ms_ff <= THRESH_W'(wr_timeout) * MS_PER_S;
               dim_ms_ff   <= THRESH_W'(wr_timeout >> 1) * MS_PER_S;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (cfg_idx)
         REG_BRIGHTNESS: prdata = DATA_W'(bright_ff);
         REG_TIMEOUT:    prdata = DATA_W'(timeout_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------- input register ----------------
   logic                  in_valid_ff;
   item_kind_type         in_kind_ff;
   logic [TIME_W-1:0]     in_now_ff;

   // ---------------- result register ----------------
   logic                  rsp_valid_ff;
   power_mode_type        rsp_mode_ff;
   logic [LEVEL_W-1:0]    rsp_level_ff;
   logic                  rsp_applied_ff;

   // ---------------- controller state ----------------
   power_mode_type        mode_ff, mode_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [TIME_W-1:0]     last_ms_ff, last_ms_in;
   logic                  applied_in;

   logic                  advance;   // result register free to load
   logic                  fire;      // an item moves into the result register
   logic                  req_take;

   assign advance  = !rsp_valid_ff || rsp_ch.ready;
   assign fire     = in_valid_ff && advance;
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= item_kind_type'(req_ch.kind);
         in_now_ff  <= req_ch.now_ms;
      end
   end

   // ---------------- decision logic ----------------
   logic [TIME_W-1:0]     elapsed_ms;
   power_mode_type        target_mode;
   logic [LEVEL_W-1:0]    target_level;

   assign elapsed_ms = in_now_ff - last_ms_ff;   // wraps mod 2^32

   always_comb begin
      target_mode  = MODE_AWAKE;
      target_level = bright_ff;
      last_ms_in   = last_ms_ff;
      priority if (in_kind_ff == KIND_ACTIVITY) begin
         last_ms_in = in_now_ff;
      end else if (timeout_ff == '0) begin
         // timeout zero: always awake
         target_mode = MODE_AWAKE;
      end else if (elapsed_ms >= TIME_W'(sleep_ms_ff)) begin
         target_mode  = MODE_ASLEEP;
         target_level = LEVEL_OFF;
      end else if (elapsed_ms >= TIME_W'(dim_ms_ff)) begin
         target_mode  = MODE_DIMMED;
         target_level = dim_lvl_ff;
      end else begin
         target_mode = MODE_AWAKE;
      end

      // a level is applied only on a real mode change
      applied_in = (target_mode != mode_ff);
      mode_in    = target_mode;
      level_in   = applied_in ? target_level : level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_AWAKE;
         level_ff   <= '0;
         last_ms_ff <= '0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         level_ff   <= level_in;
         last_ms_ff <= last_ms_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_mode_ff    <= mode_in;
         rsp_level_ff   <= level_in;
         rsp_applied_ff <= applied_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.power_mode         = rsp_mode_ff;
   assign rsp_ch.brightness         = rsp_level_ff;
   assign rsp_ch.brightness_applied = rsp_applied_ff;

`ifndef SYNTH
   // asleep always means the backlight is off
   a_sleep_dark: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ASLEEP) |-> (level_ff == LEVEL_OFF))
      else $error("asleep with nonzero level");

   // the dimmed level never falls below the floor
   a_dim_floor: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DIMMED) |-> (level_ff >= DIM_FLOOR))
      else $error("dimmed level below floor");

   // an activity event always yields an awake result
   a_activity_wakes: assert property (@(posedge clock) disable iff (reset)
      (fire && in_kind_ff == KIND_ACTIVITY) |=>
         (rsp_valid_ff && rsp_mode_ff == MODE_AWAKE && mode_ff == MODE_AWAKE))
      else $error("activity did not wake");

   // the reported result matches the state it left behind until it is taken
   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_mode_ff == mode_ff && rsp_level_ff == level_ff))
      else $error("result does not match controller state");
`endif

endmodule
